// ----- sv/ecc_pkg.sv -----
// shared types, constants and codepoint class functions for the emoji cluster collapser
// no dependencies; used by the step logic, result queue and top level
`timescale 1ns / 1ps

package ecc_pkg;

	localparam int CP_W    = 21;
	localparam int NUM_BMP = 33;
	localparam int MAX_RES = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	localparam logic [CP_W-1:0] QMARK_CP     = 21'd63;
	localparam logic [CP_W-1:0] ZWJ_CP       = 21'h0200D;
	localparam logic [CP_W-1:0] VS16_CP      = 21'h0FE0F;
	localparam logic [CP_W-1:0] VS15_CP      = 21'h0FE0E;
	localparam logic [CP_W-1:0] KEYCAP_CP    = 21'h020E3;
	localparam logic [CP_W-1:0] PICTO_LO     = 21'h1F000;
	localparam logic [CP_W-1:0] PICTO_HI     = 21'h1FAFF;
	localparam logic [CP_W-1:0] REGIONAL_LO  = 21'h1F1E6;
	localparam logic [CP_W-1:0] REGIONAL_HI  = 21'h1F1FF;
	localparam logic [CP_W-1:0] SKIN_LO      = 21'h1F3FB;
	localparam logic [CP_W-1:0] SKIN_HI      = 21'h1F3FF;
	localparam logic [CP_W-1:0] TAG_LO       = 21'hE0020;
	localparam logic [CP_W-1:0] TAG_HI       = 21'hE007F;

	localparam logic [CP_W-1:0] BMP_LO [NUM_BMP] = '{
		21'h0231A, 21'h023E9, 21'h023F0, 21'h023F3, 21'h025FD, 21'h02614, 21'h02648,
		21'h0267F, 21'h02693, 21'h026A1, 21'h026AA, 21'h026BD, 21'h026C4, 21'h026CE,
		21'h026D4, 21'h026EA, 21'h026F2, 21'h026F5, 21'h026FA, 21'h026FD, 21'h02705,
		21'h0270A, 21'h02728, 21'h0274C, 21'h0274E, 21'h02753, 21'h02757, 21'h02795,
		21'h027B0, 21'h027BF, 21'h02B1B, 21'h02B50, 21'h02B55
	};
	localparam logic [CP_W-1:0] BMP_HI [NUM_BMP] = '{
		21'h0231B, 21'h023EC, 21'h023F0, 21'h023F3, 21'h025FE, 21'h02615, 21'h02653,
		21'h0267F, 21'h02693, 21'h026A1, 21'h026AB, 21'h026BE, 21'h026C5, 21'h026CE,
		21'h026D4, 21'h026EA, 21'h026F3, 21'h026F5, 21'h026FA, 21'h026FD, 21'h02705,
		21'h0270B, 21'h02728, 21'h0274C, 21'h0274E, 21'h02755, 21'h02757, 21'h02797,
		21'h027B0, 21'h027BF, 21'h02B1C, 21'h02B50, 21'h02B55
	};

	typedef struct packed {
		logic [CP_W-1:0] held_point;
		logic            held_valid;
		logic            inside_cluster;
		logic            flag_half_open;
		logic            joiner_waiting;
	} ecc_state_t;

	// up to three results caused by one request, in order
	typedef struct packed {
		logic [RES_CNT_W-1:0]          cnt;
		logic [MAX_RES-1:0][CP_W-1:0]  cp;
		logic [MAX_RES-1:0]            last;
	} ecc_bundle_t;

	function automatic logic is_base(input logic [CP_W-1:0] c);
		logic hit;
		hit = (c >= PICTO_LO) && (c <= PICTO_HI);
		for (int k = 0; k < NUM_BMP; k++) begin
			hit = hit | ((c >= BMP_LO[k]) && (c <= BMP_HI[k]));
		end
		return hit;
	endfunction

	function automatic logic is_regional(input logic [CP_W-1:0] c);
		return (c >= REGIONAL_LO) && (c <= REGIONAL_HI);
	endfunction

	function automatic logic is_absorbable(input logic [CP_W-1:0] c);
		return (c == VS16_CP) || (c == VS15_CP) || (c == KEYCAP_CP)
			|| ((c >= SKIN_LO) && (c <= SKIN_HI))
			|| ((c >= TAG_LO) && (c <= TAG_HI));
	endfunction

	function automatic logic is_starter(input logic [CP_W-1:0] c);
		return (c == VS16_CP) || (c == KEYCAP_CP);
	endfunction

endpackage

// ----- sv/ecc_if.sv -----
// valid/ready channel interfaces for codepoint requests and results
// depends on ecc_pkg for the codepoint width
`timescale 1ns / 1ps

interface ecc_in_if;
	import ecc_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            end_of_text;

	modport source (output valid, output code_point, output end_of_text, input ready);
	modport sink (input valid, input code_point, input end_of_text, output ready);
endinterface

interface ecc_out_if;
	import ecc_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] out_code_point;
	logic            out_last;

	modport source (output valid, output out_code_point, output out_last, input ready);
	modport sink (input valid, input out_code_point, input out_last, output ready);
endinterface

// ----- sv/emoji_cluster_collapser.sv -----
// Emoji cluster collapser: replaces each emoji cluster in a codepoint stream with '?'.
//
// cp_in carries one codepoint per request with end_of_text on the final codepoint of a
// string; cp_out carries results with out_last on the final result of the string. Both
// are valid/ready channels. cfg_we/cfg_wdata write replace_enable (reset 1); write it
// only while the block is idle. With replace_enable low every codepoint passes through
// after any pending cluster or held codepoint has been flushed.
// A request is captured in an input register; from there the step logic classifies
// it against the fixed range table, updates the cluster state and pushes zero to three
// results into a four-entry result queue when the queue has room. A result is valid on
// cp_out once it has been written into the queue. One request is taken per cycle while
// each makes one result and the receiver takes every result; cp_out moves one result
// per cycle while ready is high, so requests that make two or three results hold back
// cp_in. A request leaves the input register only when the queue holds at most one
// result, so cp_in.ready depends on registers alone.
// On a stall cp_in.ready drops while a request waits on a queue of two or more results.
// Reset clears the cluster state, the input register and the queue and sets
// replace_enable to 1.
// depends on ecc_pkg, ecc_if, ecc_step and ecc_res_queue
`timescale 1ns / 1ps

module emoji_cluster_collapser
	import ecc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ecc_in_if.sink     cp_in,
	ecc_out_if.source  cp_out,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic               valid_s1;
	logic [CP_W-1:0]    cp_s1;
	logic               last_s1;
	logic               replace_enable_q;
	ecc_state_t         st_q;
	ecc_state_t         nst;
	ecc_bundle_t        bundle;
	logic [Q_CNT_W-1:0] q_count;
	logic               advance;

	// room for a full bundle of results
	assign advance     = valid_s1 && (q_count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
	assign cp_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cp_in.ready) begin
			valid_s1 <= cp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cp_in.valid && cp_in.ready) begin
			cp_s1   <= cp_in.code_point;
			last_s1 <= cp_in.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_enable_q <= 1'b1;
		end else if (cfg_we) begin
			replace_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nst;
		end
	end

	ecc_step u_step (
		.st     (st_q),
		.cp     (cp_s1),
		.last   (last_s1),
		.enable (replace_enable_q),
		.nst    (nst),
		.res    (bundle)
	);

	ecc_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.bundle (bundle),
		.count  (q_count),
		.cp_out (cp_out)
	);

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	a_held_or_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.held_valid && st_q.inside_cluster))
		else $error("held codepoint and open cluster at once");

	a_flags_need_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.joiner_waiting || st_q.flag_half_open) |-> st_q.inside_cluster)
		else $error("cluster flag set with no open cluster");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (st_q == '0))
		else $error("state not cleared after end of text");
`endif

endmodule

// ----- sv/ecc_step.sv -----
// next-state and result logic for one codepoint of the collapser
// depends on ecc_pkg for state, bundle types and class functions
`timescale 1ns / 1ps

module ecc_step
	import ecc_pkg::*;
(
	input  ecc_state_t      st,
	input  logic [CP_W-1:0] cp,
	input  logic            last,
	input  logic            enable,
	output ecc_state_t      nst,
	output ecc_bundle_t     res
);

	logic [RES_CNT_W-1:0] k;
	logic                 c_base;
	logic                 c_regional;
	logic                 c_absorb;
	logic                 c_starter;

	assign c_base     = is_base(cp);
	assign c_regional = is_regional(cp);
	assign c_absorb   = is_absorbable(cp);
	assign c_starter  = is_starter(cp);

	always_comb begin
		nst     = st;
		res.cp  = '0;
		res.last = '0;
		k       = '0;

		if (enable) begin
			// with replacement enabled, update the cluster state for this codepoint
			if (st.inside_cluster) begin
				if (st.joiner_waiting) begin
					nst.joiner_waiting = 1'b0;
					if (!c_base) begin
						res.cp[k] = QMARK_CP;
						k = k + 1'b1;
						nst.inside_cluster = 1'b0;
						nst.flag_half_open = 1'b0;
						if (c_starter) begin
							// the starter codepoint itself begins a new cluster
							nst.inside_cluster = 1'b1;
						end else begin
							res.cp[k] = ZWJ_CP;
							k = k + 1'b1;
							if (c_base) begin
								nst.inside_cluster = 1'b1;
								nst.flag_half_open = c_regional;
							end else begin
								nst.held_point = cp;
								nst.held_valid = 1'b1;
							end
						end
					end
				end else if (c_absorb) begin
					nst = st;
				end else if (st.flag_half_open && c_regional) begin
					nst.flag_half_open = 1'b0;
				end else if (cp == ZWJ_CP) begin
					nst.joiner_waiting = 1'b1;
				end else begin
					res.cp[k] = QMARK_CP;
					k = k + 1'b1;
					nst.inside_cluster = 1'b0;
					nst.flag_half_open = 1'b0;
					if (c_base) begin
						nst.inside_cluster = 1'b1;
						nst.flag_half_open = c_regional;
					end else begin
						nst.held_point = cp;
						nst.held_valid = 1'b1;
					end
				end
			end else if (st.held_valid && c_starter) begin
				// held codepoint turns out to be a cluster start
				nst.held_valid     = 1'b0;
				nst.held_point     = '0;
				nst.inside_cluster = 1'b1;
				nst.flag_half_open = 1'b0;
			end else begin
				if (st.held_valid) begin
					res.cp[k] = st.held_point;
					k = k + 1'b1;
					nst.held_valid = 1'b0;
					nst.held_point = '0;
				end
				if (c_base) begin
					nst.inside_cluster = 1'b1;
					nst.flag_half_open = c_regional;
				end else begin
					nst.held_point = cp;
					nst.held_valid = 1'b1;
				end
			end
		end

		// flush at end of text, or before a pass-through while disabled
		if (last || !enable) begin
			if (nst.inside_cluster) begin
				res.cp[k] = QMARK_CP;
				k = k + 1'b1;
				if (nst.joiner_waiting) begin
					res.cp[k] = ZWJ_CP;
					k = k + 1'b1;
				end
			end
			if (nst.held_valid) begin
				res.cp[k] = nst.held_point;
				k = k + 1'b1;
			end
			nst = '0;
		end

		if (!enable) begin
			res.cp[k] = cp;
			k = k + 1'b1;
		end

		if (last && (k != '0)) begin
			res.last[k - 1'b1] = 1'b1;
		end
		res.cnt = k;
	end

endmodule

// ----- sv/ecc_res_queue.sv -----
// small result queue: takes bundles of up to three results, one out per ready cycle
// depends on ecc_pkg and the ecc_out_if channel interface
`timescale 1ns / 1ps

module ecc_res_queue
	import ecc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ecc_bundle_t      bundle,
	output logic [Q_CNT_W-1:0] count,
	ecc_out_if.source        cp_out
);

	logic [CP_W-1:0]    cp_q   [Q_DEPTH];
	logic               last_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	logic [Q_CNT_W-1:0] count_q;
	logic [RES_CNT_W-1:0] push_cnt;
	logic               pop;

	assign push_cnt = push ? bundle.cnt : '0;
	assign pop      = cp_out.valid && cp_out.ready;
	assign count    = count_q;

	assign cp_out.valid          = (count_q != '0);
	assign cp_out.out_code_point = cp_q[rp_q];
	assign cp_out.out_last       = last_q[rp_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (RES_CNT_W'(i) < push_cnt) begin
				cp_q[wp_q + Q_PTR_W'(i)]   <= bundle.cp[i];
				last_q[wp_q + Q_PTR_W'(i)] <= bundle.last[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + Q_PTR_W'(push_cnt);
			rp_q    <= rp_q + Q_PTR_W'(pop);
			count_q <= count_q + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
		end
	end

endmodule
